### sv/sdp_pkg.sv
`timescale 1ns / 1ps
// sdp_pkg: types, codes and the half-step coil table for the stepper door positioner.
// No dependencies; imported by sdp_tick_logic and stepper_door_positioner_core.
package sdp_pkg;

    localparam int FieldPosW = 16;
    localparam int TravelW   = 16;
    localparam int CmdW      = 2;
    localparam int CoilW     = 4;
    localparam int PhaseW    = 3;

    localparam logic [CmdW-1:0] CMD_NONE  = 2'd0;
    localparam logic [CmdW-1:0] CMD_SET   = 2'd1;
    localparam logic [CmdW-1:0] CMD_CLEAR = 2'd2;

    localparam int AddrW = 3;
    localparam logic [AddrW-1:0] ADDR_FULL_TRAVEL = 3'd0;
    localparam logic [TravelW-1:0] FULL_TRAVEL_RESET = 16'd1024;

    typedef struct packed {
        logic [CmdW-1:0] open_command;
        logic            force_close_request;
        logic            close_hold;
        logic            dispensing;
    } t_in_item;

    typedef struct packed {
        logic [CoilW-1:0]     coil_pattern;
        logic [FieldPosW-1:0] step_position;
        logic                 open_latched;
        logic                 force_close_active;
    } t_out_item;

    typedef struct packed {
        logic open_latch;
        logic opened_since;
        logic force_close;
    } t_flags;

    // half-step sequence, one entry per phase
    function automatic logic [CoilW-1:0] coil_lookup(input logic [PhaseW-1:0] phase);
        logic [CoilW-1:0] pat;
        case (phase)
            3'd0: pat = 4'h1;
            3'd1: pat = 4'h9;
            3'd2: pat = 4'h8;
            3'd3: pat = 4'hC;
            3'd4: pat = 4'h4;
            3'd5: pat = 4'h6;
            3'd6: pat = 4'h2;
            3'd7: pat = 4'h3;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

### sv/stepper_door_positioner_core.sv
`timescale 1ns / 1ps
// stepper_door_positioner_core: top level of the stepper door positioner.
// Depends on sdp_pkg and sdp_tick_logic.
//
// Usage:
//   Input channel (i_in_valid / i_in_data / o_in_stall) carries one motor tick per
//   transfer. Output channel (o_out_valid / o_out_data / i_out_stall) returns one
//   result per tick: coil pattern, position, open latch and forced-close latch.
//   The APB port holds one register, full_travel, at byte address 0; the user
//   must write it only while no tick is in flight; the block does not enforce it.
// Path: a tick passes through the input register, then the result register.
//   Throughput: one tick per cycle while the output is not stalled; the tick
//   logic updates position and latches combinationally, so it does not limit
//   that rate.
// Reset (synchronous, active low): position 0, all latches clear, full_travel
//   1024, both pipeline registers empty.
// Output stall: the result register holds its value; the input register keeps
//   its tick and o_in_stall rises once it is also full. Nothing is dropped.
module stepper_door_positioner_core
    import sdp_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [AddrW-1:0]   paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [TravelW-1:0]       r_full_travel;
    logic                     r_in_valid;
    t_in_item                 r_in;
    logic                     r_out_valid;
    t_out_item                r_out;
    logic [POSITION_BITS-1:0] r_pos;
    t_flags                   r_flags;

    logic [POSITION_BITS-1:0] n_pos;
    t_flags                   n_flags;
    logic [CoilW-1:0]         n_coils;
    logic                     adv;
    logic                     in_take;
    logic                     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr == ADDR_FULL_TRAVEL) ? 32'(r_full_travel) : '0;

    // result stage can take a new tick when empty or draining this cycle
    assign adv        = !r_out_valid || !i_out_stall;
    assign in_take    = !r_in_valid || adv;
    assign o_in_stall = !in_take;

    sdp_tick_logic #(
        .POSITION_BITS(POSITION_BITS)
    ) u_tick (
        .i_item       (r_in),
        .i_pos        (r_pos),
        .i_flags      (r_flags),
        .i_full_travel(r_full_travel),
        .o_pos        (n_pos),
        .o_flags      (n_flags),
        .o_coils      (n_coils)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_travel <= FULL_TRAVEL_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_pos         <= '0;
            r_flags       <= '0;
        end else begin
            if (cfg_wr && paddr == ADDR_FULL_TRAVEL) begin
                r_full_travel <= pwdata[TravelW-1:0];
            end
            if (in_take) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (r_in_valid && adv) begin
                r_pos   <= n_pos;
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (r_in_valid && adv) begin
            r_out.coil_pattern       <= n_coils;
            r_out.step_position      <= FieldPosW'(n_pos);
            r_out.open_latched       <= n_flags.open_latch;
            r_out.force_close_active <= n_flags.force_close;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // a tick leaving the input register always lands in the result register
    a_tick_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && adv) |=> r_out_valid)
        else $error("tick lost between input and result register");

    // a held tick in the input register keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in)))
        else $error("input register changed while blocked");

    // half stepping never energizes more than two coils
    a_coils: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($countones(r_out.coil_pattern) <= 2))
        else $error("more than two coils driven");
`endif

endmodule

### sv/sdp_tick_logic.sv
`timescale 1ns / 1ps
// sdp_tick_logic: combinational next-state and coil output for one motor tick.
// Depends on sdp_pkg.
module sdp_tick_logic
    import sdp_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  t_in_item                 i_item,
    input  logic [POSITION_BITS-1:0] i_pos,
    input  t_flags                   i_flags,
    input  logic [TravelW-1:0]       i_full_travel,
    output logic [POSITION_BITS-1:0] o_pos,
    output t_flags                   o_flags,
    output logic [CoilW-1:0]         o_coils
);

    localparam int LimW = (POSITION_BITS > TravelW) ? POSITION_BITS : TravelW;
    localparam logic [POSITION_BITS-1:0] PosMax = '1;

    logic [LimW-1:0]          travel_ext;
    logic [POSITION_BITS-1:0] limit;
    logic                     force_l;
    logic                     open_l;
    logic [POSITION_BITS-1:0] close_start;

    assign travel_ext = LimW'(i_full_travel);
    // saturate full travel to what the position register can hold
    assign limit = (travel_ext > LimW'(PosMax)) ? PosMax : POSITION_BITS'(travel_ext);

    always_comb begin
        force_l = i_flags.force_close | i_item.force_close_request;
        case (i_item.open_command)
            CMD_SET:   open_l = 1'b1;
            CMD_CLEAR: open_l = 1'b0;
            default:   open_l = i_flags.open_latch;
        endcase
        close_start = i_flags.opened_since ? limit : i_pos;

        o_pos                = i_pos;
        o_flags.force_close  = force_l;
        o_flags.open_latch   = open_l;
        o_flags.opened_since = i_flags.opened_since;

        if (force_l) begin
            if (i_pos != '0) begin
                if (!i_item.close_hold) begin
                    o_pos = i_pos - POSITION_BITS'(1);
                end
            end else begin
                o_flags.force_close = 1'b0;
            end
        end else if (open_l) begin
            o_flags.opened_since = 1'b1;
            if (i_pos < limit) begin
                o_pos = i_pos + POSITION_BITS'(1);
            end else begin
                o_pos = limit;
                if (!i_item.dispensing) begin
                    o_flags.open_latch = 1'b0;
                end
            end
        end else begin
            // closing after an open snaps to full travel first
            o_flags.opened_since = 1'b0;
            if (close_start != '0 && !i_item.close_hold) begin
                o_pos = close_start - POSITION_BITS'(1);
            end else begin
                o_pos = close_start;
            end
        end

        if (o_pos == '0 || o_pos == limit) begin
            o_coils = '0;
        end else begin
            o_coils = coil_lookup(o_pos[PhaseW-1:0]);
        end
    end

endmodule

### tb/sv/tb_stepper_door_positioner_core.sv
`timescale 1ns / 1ps
// tb_stepper_door_positioner_core: self-checking testbench for the stepper door positioner.
// Drives motor ticks and full_travel writes, predicts every result and compares per field.
// Depends on sdp_pkg and stepper_door_positioner_core.
module tb_stepper_door_positioner_core;
    import sdp_pkg::*;

    localparam int PosW = 16;
    localparam logic [CmdW-1:0] CMD_IGNORED = 2'd3;
    // coil pattern per half-step phase, phase 0 in the low nibble
    localparam logic [31:0] HALF_STEP_SEQ = 32'h3264_C891;
    localparam int TARGET_TICKS = 1850;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT = 600000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out_data;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    // predicted door state
    logic [TravelW-1:0] travel_cfg;
    logic [PosW-1:0]    door_pos;
    logic               open_held;
    logic               was_opened;
    logic               forced_close;

    t_out_item door_status_q[$];
    int        sent_ticks = 0;
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        in_gaps = 1'b0;
    bit        out_stalls = 1'b0;

    stepper_door_positioner_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // advances the predicted door by one tick and returns the status it reports
    function automatic t_out_item step_door(input t_in_item tick);
        t_out_item status;
        logic [PosW-1:0] limit;
        limit = travel_cfg;
        if (tick.force_close_request) forced_close = 1'b1;
        if (tick.open_command == CMD_SET) begin
            open_held = 1'b1;
        end else if (tick.open_command == CMD_CLEAR) begin
            open_held = 1'b0;
        end
        if (forced_close) begin
            if (door_pos != '0) begin
                if (!tick.close_hold) door_pos = door_pos - 1'b1;
            end else begin
                forced_close = 1'b0;
            end
        end else if (open_held) begin
            was_opened = 1'b1;
            if (door_pos < limit) begin
                door_pos = door_pos + 1'b1;
            end else begin
                door_pos = limit;
                if (!tick.dispensing) open_held = 1'b0;
            end
        end else begin
            // first closing tick after an open starts from full travel
            if (was_opened) begin
                door_pos = limit;
                was_opened = 1'b0;
            end
            if (door_pos != '0 && !tick.close_hold) door_pos = door_pos - 1'b1;
        end
        if (door_pos == '0 || door_pos == limit) begin
            status.coil_pattern = '0;
        end else begin
            status.coil_pattern = HALF_STEP_SEQ[door_pos[2:0]*4 +: 4];
        end
        status.step_position = door_pos[FieldPosW-1:0];
        status.open_latched = open_held;
        status.force_close_active = forced_close;
        return status;
    endfunction

    function automatic t_in_item make_tick(input logic [CmdW-1:0] cmd, input logic force_req,
                                           input logic hold, input logic disp);
        t_in_item tick;
        tick.open_command = cmd;
        tick.force_close_request = force_req;
        tick.close_hold = hold;
        tick.dispensing = disp;
        return tick;
    endfunction

    function automatic t_in_item random_tick(input int set_pct, input int clr_pct);
        int pick;
        logic [CmdW-1:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < set_pct) begin
            cmd = CMD_SET;
        end else if (pick < set_pct + clr_pct) begin
            cmd = CMD_CLEAR;
        end else if (pick < set_pct + clr_pct + 2) begin
            cmd = CMD_IGNORED;
        end else begin
            cmd = CMD_NONE;
        end
        return make_tick(cmd, $urandom_range(0, 39) == 0, $urandom_range(0, 6) == 0,
                         $urandom_range(0, 2) == 0);
    endfunction

    task automatic send_tick(input t_in_item tick);
        int gap;
        if (in_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= tick;
        do @(posedge i_clk); while (o_in_stall);
        door_status_q.push_back(step_door(tick));
        sent_ticks++;
    endtask

    task automatic wait_drained;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (door_status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_full_travel(input logic [TravelW-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_FULL_TRAVEL;
        pwdata <= {{(32 - TravelW){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        travel_cfg = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reset_block;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        travel_cfg = FULL_TRAVEL_RESET;
        door_pos = '0;
        open_held = 1'b0;
        was_opened = 1'b0;
        forced_close = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // open a little at the reset travel, then close so the position snaps to full travel
    task automatic test_reset_travel;
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_SET, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(CMD_IGNORED, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_CLEAR, 1'b0, 1'b1, 1'b0));
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b0));
        wait_drained;
    endtask

    // travel lowered under the current position, then dispensing hold and forced close
    task automatic test_position_above_travel;
        set_full_travel(16'd4);
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b1, 1'b0));
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_SET, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_NONE, 1'b1, 1'b1, 1'b0));
        send_tick(make_tick(CMD_SET, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b0));
        wait_drained;
    endtask

    task automatic test_travel_extremes;
        set_full_travel(16'd1);
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_SET, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_CLEAR, 1'b0, 1'b1, 1'b0));
        wait_drained;
        // zero travel: opening is complete at once
        set_full_travel(16'd0);
        send_tick(make_tick(CMD_SET, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_NONE, 1'b1, 1'b1, 1'b1));
        wait_drained;
        set_full_travel(16'hFFFF);
        send_tick(make_tick(CMD_SET, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(CMD_NONE, 1'b0, 1'b1, 1'b1));
        send_tick(make_tick(CMD_IGNORED, 1'b1, 1'b1, 1'b0));
        send_tick(make_tick(CMD_CLEAR, 1'b0, 1'b0, 1'b0));
        wait_drained;
    endtask

    task automatic run_door_cycle(input int reach);
        int n;
        send_tick(make_tick(CMD_SET, $urandom_range(0, 15) == 0, $urandom_range(0, 1) == 1,
                            $urandom_range(0, 1) == 1));
        n = reach + $urandom_range(0, 6);
        repeat (n) send_tick(random_tick(0, 2));
        send_tick(make_tick(CMD_CLEAR, $urandom_range(0, 15) == 0, $urandom_range(0, 1) == 1,
                            $urandom_range(0, 1) == 1));
        n = reach + $urandom_range(0, 6);
        repeat (n) send_tick(random_tick(2, 0));
    endtask

    task automatic test_random_door_cycles;
        int travel;
        int reach;
        bit last_part;
        while (sent_ticks < TARGET_TICKS) begin
            wait_drained;
            case ($urandom_range(0, 9))
                0: travel = 65535;
                1: travel = $urandom_range(1, 3);
                default: travel = $urandom_range(4, 40);
            endcase
            set_full_travel(travel[TravelW-1:0]);
            last_part = sent_ticks > (TARGET_TICKS * 85) / 100;
            in_gaps = !last_part && $urandom_range(0, 3) != 0;
            out_stalls = !last_part && $urandom_range(0, 3) != 0;
            reach = (travel > 48) ? 48 : travel;
            repeat ($urandom_range(2, 4)) begin
                if ($urandom_range(0, 4) == 0) begin
                    // broken sequences: commands in any order
                    repeat ($urandom_range(8, 24)) send_tick(random_tick(25, 25));
                end else begin
                    run_door_cycle(reach);
                end
            end
        end
    endtask

    // receiver stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (out_stalls && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (door_status_q.size() == 0) begin
                $error("result transfer with no tick outstanding");
                fail_count++;
            end else begin
                want = door_status_q.pop_front();
                if (o_out_data.coil_pattern !== want.coil_pattern) begin
                    $error("coil_pattern: expected %h, actual %h",
                           want.coil_pattern, o_out_data.coil_pattern);
                    fail_count++;
                end
                if (o_out_data.step_position !== want.step_position) begin
                    $error("step_position: expected %0d, actual %0d",
                           want.step_position, o_out_data.step_position);
                    fail_count++;
                end
                if (o_out_data.open_latched !== want.open_latched) begin
                    $error("open_latched: expected %b, actual %b",
                           want.open_latched, o_out_data.open_latched);
                    fail_count++;
                end
                if (o_out_data.force_close_active !== want.force_close_active) begin
                    $error("force_close_active: expected %b, actual %b",
                           want.force_close_active, o_out_data.force_close_active);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        reset_block;
        in_gaps = 1'b1;
        out_stalls = 1'b1;
        test_reset_travel;
        test_position_above_travel;
        test_travel_extremes;
        test_random_door_cycles;
        wait_drained;
        if (fail_count == 0 && door_status_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
sv/sdp_pkg.sv
sv/sdp_tick_logic.sv
sv/stepper_door_positioner_core.sv
tb/sv/tb_stepper_door_positioner_core.sv
